// File: src/urb_pkg.sv
// Shared types and constants for the serial-port ring buffer pair.
// Has no dependencies. The interfaces, the ring and the top level import it.
`default_nettype none

package urb_pkg;

    localparam int BYTE_W        = 8;
    localparam int OP_W          = 3;
    localparam int COUNT_W       = 4;
    localparam int RX_DEPTH_DEF  = 16;
    localparam int TX_DEPTH_DEF  = 16;

    // Event codes carried in the op field. Code seven is unused and does nothing.
    typedef enum logic [OP_W-1:0] {
        OP_LINE_RX       = 3'd0,
        OP_LINE_TX_READY = 3'd1,
        OP_LINE_ERROR    = 3'd2,
        OP_HOST_READ     = 3'd3,
        OP_HOST_WRITE    = 3'd4,
        OP_FLUSH_RX      = 3'd5,
        OP_FLUSH_TX      = 3'd6
    } t_op;

    typedef enum logic {
        ST_IDLE   = 1'b0,
        ST_RESULT = 1'b1
    } t_state;

    // Command from the control logic to one ring.
    typedef struct packed {
        logic push;
        logic pop;
        logic flush;
    } t_ring_cmd;

    // Status returned by one ring.
    typedef struct packed {
        logic               empty;
        logic               full;
        logic [COUNT_W-1:0] count;
    } t_ring_stat;

endpackage

`default_nettype wire

// File: src/urb_item_if.sv
// Input channel of the ring buffer pair: one event item with valid and ready.
// Depends on urb_pkg for the field widths.
`default_nettype none

interface urb_item_if
    import urb_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   op;
    logic [BYTE_W-1:0] line_data;
    logic [BYTE_W-1:0] write_data;

    modport source (output valid, op, line_data, write_data, input ready);
    modport sink   (input valid, op, line_data, write_data, output ready);
endinterface

`default_nettype wire

// File: src/urb_result_if.sv
// Output channel of the ring buffer pair: one result item with valid and ready.
// Depends on urb_pkg for the field widths.
`default_nettype none

interface urb_result_if
    import urb_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [BYTE_W-1:0]  read_data;
    logic               read_valid;
    logic [BYTE_W-1:0]  send_byte;
    logic               send_valid;
    logic               tx_enabled;
    logic               error_seen;
    logic               overflow;
    logic [COUNT_W-1:0] rx_count;
    logic [COUNT_W-1:0] tx_count;

    modport source (
        output valid, read_data, read_valid, send_byte, send_valid,
               tx_enabled, error_seen, overflow, rx_count, tx_count,
        input  ready
    );
    modport sink (
        input  valid, read_data, read_valid, send_byte, send_valid,
               tx_enabled, error_seen, overflow, rx_count, tx_count,
        output ready
    );
endinterface

`default_nettype wire

// File: src/uart_ring_buffer_pair_core.sv
// Top level of the serial-port ring buffer pair: event decode, transmitter
// enable, result register. Depends on urb_pkg, urb_item_if, urb_result_if, urb_ring.
//
// The block keeps a receive ring and a transmit ring, each a synchronous byte
// memory with head and tail pointers, and handles one event item at a time.
// An accepted item updates the pointers and the transmitter enable at once and
// launches the memory write or read; the registered memory read data is built
// into the output register in the ST_RESULT state that follows. The result
// item therefore shows valid once that state has loaded the output register,
// and the input takes no new item before then; after that, a new item is
// accepted as long as the result side keeps up. The input waits while the
// previous result still sits unclaimed in the output register and the new
// item could not get a free slot in it. Because only one item is in flight, a
// memory write and a later read of the same entry never overlap. A ring of
// depth D holds up to D-1 bytes; a byte that arrives at a full ring is dropped
// and the result flags overflow. Every result carries both fill counts, cut
// to four bits, and the transmitter enable after the event. No clearing pass
// runs after reset: the memories hold nothing that is read before it has
// been written.
`default_nettype none

module uart_ring_buffer_pair_core
    import urb_pkg::*;
#(
    parameter int RX_DEPTH = RX_DEPTH_DEF,
    parameter int TX_DEPTH = TX_DEPTH_DEF
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    urb_item_if.sink     i_item,
    urb_result_if.source o_result
);

    t_state r_state, n_state;

    t_ring_cmd         rx_cmd, tx_cmd;
    t_ring_stat        rx_stat, tx_stat;
    logic [BYTE_W-1:0] rx_rdata, tx_rdata;

    t_op  op;
    logic accept;
    logic load_result;
    logic in_ready;

    // Sending state of the transmitter, and flags kept for the result cycle.
    logic r_sending, n_sending;
    logic r_rd_valid, n_rd_valid;
    logic r_snd_valid, n_snd_valid;
    logic r_err, n_err;
    logic r_ovf, n_ovf;

    // Output register.
    logic               r_out_valid;
    logic [BYTE_W-1:0]  r_read_data;
    logic               r_read_valid;
    logic [BYTE_W-1:0]  r_send_byte;
    logic               r_send_valid;
    logic               r_tx_enabled;
    logic               r_error_seen;
    logic               r_overflow;
    logic [COUNT_W-1:0] r_rx_count;
    logic [COUNT_W-1:0] r_tx_count;

    assign op     = t_op'(i_item.op);
    assign accept = i_item.valid && in_ready;

    // Next state: an accepted item always passes through ST_RESULT, waiting for memory data.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_state = ST_RESULT;
                end
            end
            ST_RESULT: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Handshake outputs of the state machine. The output register is free for
    // the next result if it is empty or is being emptied at this edge.
    always_comb begin
        in_ready    = 1'b0;
        load_result = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                in_ready = !r_out_valid || o_result.ready;
            end
            ST_RESULT: begin
                load_result = 1'b1;
            end
            default: begin
                in_ready = 1'b0;
            end
        endcase
    end

    assign i_item.ready = in_ready;

    // Event decode: ring commands, transmitter enable and result flags.
    always_comb begin
        rx_cmd      = '0;
        tx_cmd      = '0;
        n_sending   = r_sending;
        n_rd_valid  = 1'b0;
        n_snd_valid = 1'b0;
        n_err       = 1'b0;
        n_ovf       = 1'b0;
        if (accept) begin
            unique case (op)
                OP_LINE_RX: begin
                    rx_cmd.push = !rx_stat.full;
                    n_ovf       = rx_stat.full;
                end
                OP_LINE_TX_READY: begin
                    // The ready event is masked while the transmitter is off.
                    if (r_sending) begin
                        if (tx_stat.empty) begin
                            n_sending = 1'b0;
                        end else begin
                            tx_cmd.pop  = 1'b1;
                            n_snd_valid = 1'b1;
                        end
                    end
                end
                OP_LINE_ERROR: begin
                    n_err = 1'b1;
                end
                OP_HOST_READ: begin
                    rx_cmd.pop = !rx_stat.empty;
                    n_rd_valid = !rx_stat.empty;
                end
                OP_HOST_WRITE: begin
                    tx_cmd.push = !tx_stat.full;
                    n_ovf       = tx_stat.full;
                    // The first byte into an empty ring starts the transmitter.
                    if (!tx_stat.full && tx_stat.empty) begin
                        n_sending = 1'b1;
                    end
                end
                OP_FLUSH_RX: begin
                    rx_cmd.flush = 1'b1;
                end
                OP_FLUSH_TX: begin
                    tx_cmd.flush = 1'b1;
                end
                default: begin
                    n_sending = r_sending;
                end
            endcase
        end
    end

    urb_ring #(
        .DEPTH (RX_DEPTH)
    ) u_rx_ring (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (rx_cmd),
        .i_wdata (i_item.line_data),
        .o_stat  (rx_stat),
        .o_rdata (rx_rdata)
    );

    urb_ring #(
        .DEPTH (TX_DEPTH)
    ) u_tx_ring (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (tx_cmd),
        .i_wdata (i_item.write_data),
        .o_stat  (tx_stat),
        .o_rdata (tx_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_sending   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_sending <= n_sending;
            if (load_result) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Flags of the accepted item, held until its memory data is back.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_rd_valid  <= n_rd_valid;
            r_snd_valid <= n_snd_valid;
            r_err       <= n_err;
            r_ovf       <= n_ovf;
        end
    end

    // Result payload. The pointers and the enable already hold their values
    // after the event, so the counts and tx_enabled are read straight off them.
    always_ff @(posedge i_clk) begin
        if (load_result) begin
            r_read_data  <= r_rd_valid ? rx_rdata : '0;
            r_read_valid <= r_rd_valid;
            r_send_byte  <= r_snd_valid ? tx_rdata : '0;
            r_send_valid <= r_snd_valid;
            r_tx_enabled <= r_sending;
            r_error_seen <= r_err;
            r_overflow   <= r_ovf;
            r_rx_count   <= rx_stat.count;
            r_tx_count   <= tx_stat.count;
        end
    end

    assign o_result.valid      = r_out_valid;
    assign o_result.read_data  = r_read_data;
    assign o_result.read_valid = r_read_valid;
    assign o_result.send_byte  = r_send_byte;
    assign o_result.send_valid = r_send_valid;
    assign o_result.tx_enabled = r_tx_enabled;
    assign o_result.error_seen = r_error_seen;
    assign o_result.overflow   = r_overflow;
    assign o_result.rx_count   = r_rx_count;
    assign o_result.tx_count   = r_tx_count;

endmodule

`default_nettype wire

// File: src/urb_ring.sv
// One byte ring: a synchronous byte memory with head and tail pointers.
// Depends on urb_pkg for the command and status types.
`default_nettype none

module urb_ring
    import urb_pkg::*;
#(
    parameter int DEPTH = RX_DEPTH_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_ring_cmd         i_cmd,
    input  wire logic [BYTE_W-1:0] i_wdata,
    output t_ring_stat             o_stat,
    output logic [BYTE_W-1:0]      o_rdata
);

    localparam int AW = $clog2(DEPTH);
    localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

    logic [BYTE_W-1:0] r_mem [DEPTH];
    logic [BYTE_W-1:0] r_rdata;
    logic [AW-1:0]     r_head, n_head;
    logic [AW-1:0]     r_tail, n_tail;
    logic [AW-1:0]     head_adv, tail_adv;
    logic [AW:0]       diff, diff_wrap;
    logic [AW-1:0]     count;

    assign head_adv = (r_head == LAST) ? '0 : r_head + 1'b1;
    assign tail_adv = (r_tail == LAST) ? '0 : r_tail + 1'b1;

    // The ring is full when one more byte would make tail meet head.
    assign o_stat.empty = (r_head == r_tail);
    assign o_stat.full  = (tail_adv == r_head);

    assign diff      = {1'b0, r_tail} - {1'b0, r_head};
    assign diff_wrap = diff + (AW+1)'(DEPTH);
    assign count     = (r_tail >= r_head) ? diff[AW-1:0] : diff_wrap[AW-1:0];

    generate
        if (AW >= COUNT_W) begin : g_cnt_trunc
            assign o_stat.count = count[COUNT_W-1:0];
        end else begin : g_cnt_ext
            assign o_stat.count = {{(COUNT_W-AW){1'b0}}, count};
        end
    endgenerate

    always_comb begin
        n_head = r_head;
        n_tail = r_tail;
        if (i_cmd.flush) begin
            n_head = '0;
            n_tail = '0;
        end else begin
            if (i_cmd.pop) begin
                n_head = head_adv;
            end
            if (i_cmd.push) begin
                n_tail = tail_adv;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
            r_tail <= '0;
        end else begin
            r_head <= n_head;
            r_tail <= n_tail;
        end
    end

    // Memory: one write port at the tail, one registered read port at the head.
    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_mem[r_tail] <= i_wdata;
        end
        if (i_cmd.pop) begin
            r_rdata <= r_mem[r_head];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// File: src/urb_checker.sv
// Port-level checks for the serial-port ring buffer pair, and their binding.
// Depends on uart_ring_buffer_pair_core and the widths in urb_pkg.
`default_nettype none

module urb_checker
    import urb_pkg::*;
(
    input wire logic              i_clk,
    input wire logic              i_rst_n,
    input wire logic              i_in_valid,
    input wire logic              i_in_ready,
    input wire logic              i_out_valid,
    input wire logic [BYTE_W-1:0] i_read_data,
    input wire logic              i_read_valid,
    input wire logic [BYTE_W-1:0] i_send_byte,
    input wire logic              i_send_valid,
    input wire logic              i_error_seen,
    input wire logic              i_overflow
);

    // Only one item is in flight, so the cycle after an acceptance takes nothing.
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_in_ready)
        else $error("item accepted while another is still in flight");

    // An accepted item is followed by a valid result once the output register has loaded.
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> ##1 i_out_valid)
        else $error("no result for an accepted item");

    // Each event raises at most one of the event flags.
    a_flags_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> $onehot0({i_read_valid, i_send_valid, i_error_seen, i_overflow}))
        else $error("result carries flags of more than one event");

    // Data bytes are zero whenever their valid bit is clear.
    a_idle_bytes_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> ((i_read_valid || (i_read_data == '0)) &&
                         (i_send_valid || (i_send_byte == '0))))
        else $error("data byte set without its valid bit");

    // Reset leaves no result pending.
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid right after reset");

endmodule

bind uart_ring_buffer_pair_core urb_checker u_urb_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_item.valid),
    .i_in_ready   (i_item.ready),
    .i_out_valid  (o_result.valid),
    .i_read_data  (o_result.read_data),
    .i_read_valid (o_result.read_valid),
    .i_send_byte  (o_result.send_byte),
    .i_send_valid (o_result.send_valid),
    .i_error_seen (o_result.error_seen),
    .i_overflow   (o_result.overflow)
);

`default_nettype wire

// File: test/urb_ring_checker.sv
// Checker for the serial-port ring buffer pair: watches both channels, predicts
// every result item from the accepted event items and compares them in order.
// Depends on urb_pkg, urb_item_if and urb_result_if.

module urb_ring_checker
    import urb_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    urb_item_if       i_item,
    urb_result_if     i_result,
    output int        o_fail_count,
    output int        o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RX_SLOTS   = RX_DEPTH_DEF;
    localparam int TX_SLOTS   = TX_DEPTH_DEF;
    localparam int SHOW_LIMIT = 10;

    typedef struct packed {
        logic [BYTE_W-1:0]  read_data;
        logic               read_valid;
        logic [BYTE_W-1:0]  send_byte;
        logic               send_valid;
        logic               tx_enabled;
        logic               error_seen;
        logic               overflow;
        logic [COUNT_W-1:0] rx_count;
        logic [COUNT_W-1:0] tx_count;
    } t_event_result;

    // Shadow copy of both rings and the transmitter enable.
    logic [BYTE_W-1:0] rx_bytes [RX_SLOTS];
    logic [BYTE_W-1:0] tx_bytes [TX_SLOTS];
    int                rx_head;
    int                rx_tail;
    int                tx_head;
    int                tx_tail;
    logic              tx_on;

    t_event_result     awaited_results [$];
    int                fail_total;
    int                shown;

    function automatic int ring_next(input int ptr, input int slots);
        return (ptr + 1 >= slots) ? 0 : ptr + 1;
    endfunction

    function automatic logic [COUNT_W-1:0] ring_fill(input int head, input int tail,
                                                     input int slots);
        int n;
        n = (tail >= head) ? tail - head : tail + slots - head;
        return n[COUNT_W-1:0];
    endfunction

    function automatic string show_result(input t_event_result r);
        return $sformatf("rd=%h rv=%b sb=%h sv=%b txen=%b err=%b ovf=%b rxc=%0d txc=%0d",
                         r.read_data, r.read_valid, r.send_byte, r.send_valid,
                         r.tx_enabled, r.error_seen, r.overflow, r.rx_count, r.tx_count);
    endfunction

    // Applies one event to the shadow rings and returns the result it causes.
    function automatic t_event_result apply_event(input logic [OP_W-1:0] op,
                                                  input logic [BYTE_W-1:0] line_byte,
                                                  input logic [BYTE_W-1:0] host_byte);
        t_event_result res;
        int            nxt;
        res = '0;
        case (op)
            OP_LINE_RX: begin
                nxt = ring_next(rx_tail, RX_SLOTS);
                if (nxt == rx_head) begin
                    res.overflow = 1'b1;
                end else begin
                    rx_bytes[rx_tail] = line_byte;
                    rx_tail = nxt;
                end
            end
            OP_LINE_TX_READY: begin
                // The ready event is masked while the transmitter is off.
                if (tx_on) begin
                    if (tx_head == tx_tail) begin
                        tx_on = 1'b0;
                    end else begin
                        res.send_byte  = tx_bytes[tx_head];
                        res.send_valid = 1'b1;
                        tx_head = ring_next(tx_head, TX_SLOTS);
                    end
                end
            end
            OP_LINE_ERROR: begin
                res.error_seen = 1'b1;
            end
            OP_HOST_READ: begin
                if (rx_head != rx_tail) begin
                    res.read_data  = rx_bytes[rx_head];
                    res.read_valid = 1'b1;
                    rx_head = ring_next(rx_head, RX_SLOTS);
                end
            end
            OP_HOST_WRITE: begin
                nxt = ring_next(tx_tail, TX_SLOTS);
                if (nxt == tx_head) begin
                    res.overflow = 1'b1;
                end else begin
                    if (tx_head == tx_tail) begin
                        tx_on = 1'b1;
                    end
                    tx_bytes[tx_tail] = host_byte;
                    tx_tail = nxt;
                end
            end
            OP_FLUSH_RX: begin
                rx_head = 0;
                rx_tail = 0;
            end
            OP_FLUSH_TX: begin
                tx_head = 0;
                tx_tail = 0;
            end
            default: begin
            end
        endcase
        res.tx_enabled = tx_on;
        res.rx_count   = ring_fill(rx_head, rx_tail, RX_SLOTS);
        res.tx_count   = ring_fill(tx_head, tx_tail, TX_SLOTS);
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_event_result got;
        t_event_result want;
        if (!i_rst_n) begin
            rx_head = 0;
            rx_tail = 0;
            tx_head = 0;
            tx_tail = 0;
            tx_on   = 1'b0;
            awaited_results.delete();
        end else begin
            if (i_item.valid && i_item.ready) begin
                awaited_results.push_back(apply_event(i_item.op, i_item.line_data,
                                                      i_item.write_data));
            end
            if (i_result.valid && i_result.ready) begin
                got.read_data  = i_result.read_data;
                got.read_valid = i_result.read_valid;
                got.send_byte  = i_result.send_byte;
                got.send_valid = i_result.send_valid;
                got.tx_enabled = i_result.tx_enabled;
                got.error_seen = i_result.error_seen;
                got.overflow   = i_result.overflow;
                got.rx_count   = i_result.rx_count;
                got.tx_count   = i_result.tx_count;
                if (awaited_results.size() == 0) begin
                    fail_total++;
                    if (shown < SHOW_LIMIT) begin
                        $display("%0t: result item with none awaited: %s", $realtime,
                                 show_result(got));
                    end
                    shown++;
                end else begin
                    want = awaited_results.pop_front();
                    if (got.read_data  !== want.read_data  ||
                        got.read_valid !== want.read_valid ||
                        got.send_byte  !== want.send_byte  ||
                        got.send_valid !== want.send_valid ||
                        got.tx_enabled !== want.tx_enabled ||
                        got.error_seen !== want.error_seen ||
                        got.overflow   !== want.overflow   ||
                        got.rx_count   !== want.rx_count   ||
                        got.tx_count   !== want.tx_count) begin
                        fail_total++;
                        if (shown < SHOW_LIMIT) begin
                            $display("%0t: result mismatch", $realtime);
                            $display("    expected %s", show_result(want));
                            $display("    actual   %s", show_result(got));
                        end
                        shown++;
                    end
                end
            end
        end
        o_pending    <= awaited_results.size();
        o_fail_count <= fail_total;
    end

endmodule

// File: test/tb_top.sv
// Top of the ring buffer pair testbench: clock, reset, event stimulus, result
// side back-pressure, watchdog and verdict. Uses urb_pkg, both channel
// interfaces, uart_ring_buffer_pair_core and urb_ring_checker.

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import urb_pkg::*;

    // The op field is three bits wide; its last code has no event behind it.
    localparam logic [OP_W-1:0] OP_UNUSED = 3'd7;

    localparam int RESET_CYCLES    = 6;
    localparam int PHASE_ITEMS     = 600;
    localparam int HOLD_CYCLES     = 300;
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int TAIL_CYCLES     = 8;

    // Flavors of random traffic. Filling one ring is what drives it to full
    // and into overflow; draining brings the transmitter back to off.
    typedef enum {
        MIX_FILL_RX,
        MIX_FILL_TX,
        MIX_DRAIN,
        MIX_BALANCED,
        MIX_NOISE
    } t_mix;

    logic i_clk = 1'b0;
    logic i_rst_n;

    int   src_idle_pct;
    int   sink_idle_pct;
    int   hold_requests;
    int   fail_count;
    int   pending;

    urb_item_if   item_ch ();
    urb_result_if result_ch ();

    uart_ring_buffer_pair_core u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (item_ch),
        .o_result (result_ch)
    );

    urb_ring_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item       (item_ch),
        .i_result     (result_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always #5 i_clk = ~i_clk;

    // Offers one event item and returns at the edge that accepts it. Valid is
    // left high, so back-to-back items keep it asserted without a glitch.
    // Before offering, the sender idles cycle by cycle at the current rate.
    task automatic send_event(input logic [OP_W-1:0] op,
                              input logic [BYTE_W-1:0] line_byte,
                              input logic [BYTE_W-1:0] host_byte);
        while ($urandom_range(99) < src_idle_pct) begin
            item_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        item_ch.valid      <= 1'b1;
        item_ch.op         <= op;
        item_ch.line_data  <= line_byte;
        item_ch.write_data <= host_byte;
        @(posedge i_clk);
        while (!item_ch.ready) @(posedge i_clk);
    endtask

    // Stops offering and waits until the checker has seen every result it
    // predicted. The first edge lets the count of the last accepted item land.
    task automatic wait_drained();
        item_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    function automatic logic [OP_W-1:0] pick_op(input t_mix mode);
        int r;
        r = $urandom_range(99);
        case (mode)
            MIX_FILL_RX: begin
                if (r < 80) return OP_LINE_RX;
                if (r < 90) return OP_HOST_READ;
            end
            MIX_FILL_TX: begin
                if (r < 80) return OP_HOST_WRITE;
                if (r < 90) return OP_LINE_TX_READY;
            end
            MIX_DRAIN: begin
                if (r < 45) return OP_HOST_READ;
                if (r < 90) return OP_LINE_TX_READY;
            end
            MIX_BALANCED: begin
                if (r < 24) return OP_LINE_RX;
                if (r < 48) return OP_LINE_TX_READY;
                if (r < 72) return OP_HOST_READ;
                if (r < 96) return OP_HOST_WRITE;
            end
            default: begin
            end
        endcase
        // Everything else, unused code included, is uniform noise.
        return OP_W'($urandom_range(7));
    endfunction

    // Random traffic in segments of one flavor each, with random bytes in
    // both data fields whatever the op.
    task automatic run_mix(input int n_items);
        int   left;
        int   seg;
        t_mix mode;
        left = n_items;
        while (left > 0) begin
            mode = t_mix'($urandom_range(4));
            seg  = $urandom_range(4, 40);
            if (seg > left) seg = left;
            repeat (seg) begin
                send_event(pick_op(mode), BYTE_W'($urandom_range(255)),
                           BYTE_W'($urandom_range(255)));
            end
            left -= seg;
        end
    endtask

    // Result side. Ready is redrawn every cycle from the current idle rate,
    // except during a requested hold-off, which this process counts itself.
    initial begin : sink_side
        int hold_left;
        int holds_served;
        hold_left    = 0;
        holds_served = 0;
        result_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (!i_rst_n) begin
                result_ch.ready <= 1'b0;
            end else if (holds_served != hold_requests) begin
                holds_served++;
                hold_left = HOLD_CYCLES;
                result_ch.ready <= 1'b0;
            end else if (hold_left != 0) begin
                hold_left--;
                result_ch.ready <= 1'b0;
            end else begin
                result_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
            end
        end
    end

    // Ends the run if neither channel moves an item for too long.
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || (item_ch.valid && item_ch.ready) ||
                (result_ch.valid && result_ch.ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("Test completed with failures");
        $finish;
    end

    initial begin
        i_rst_n            <= 1'b0;
        item_ch.valid      <= 1'b0;
        item_ch.op         <= OP_LINE_RX;
        item_ch.line_data  <= '0;
        item_ch.write_data <= '0;
        hold_requests      <= 0;
        sink_idle_pct      <= 0;
        src_idle_pct = 0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Phase one: sender idles now and then, receiver about half the time.
        src_idle_pct = 15;
        sink_idle_pct <= 51;

        // Directed opening: an empty read, the masked ready event, the error
        // pulse and the unused code, then the transmitter turning on with a
        // write into an empty ring and back off on a ready with nothing left.
        send_event(OP_HOST_READ,     8'h00, 8'h00);
        send_event(OP_LINE_TX_READY, 8'hFF, 8'hFF);
        send_event(OP_LINE_ERROR,    8'hFF, 8'h00);
        send_event(OP_UNUSED,        8'hFF, 8'hFF);
        send_event(OP_HOST_WRITE,    8'hFF, 8'h00);
        send_event(OP_HOST_WRITE,    8'h00, 8'hFF);
        send_event(OP_LINE_TX_READY, 8'h00, 8'h00);
        send_event(OP_LINE_TX_READY, 8'h00, 8'h00);
        send_event(OP_LINE_TX_READY, 8'h00, 8'h00);
        // Receive side with both extreme bytes, a partial read, then a flush
        // of a ring that still holds data and a read that finds it empty.
        send_event(OP_LINE_RX,       8'h00, 8'hFF);
        send_event(OP_LINE_RX,       8'hFF, 8'h00);
        send_event(OP_LINE_RX,       8'h5A, 8'hA5);
        send_event(OP_HOST_READ,     8'h00, 8'h00);
        send_event(OP_FLUSH_RX,      8'hFF, 8'hFF);
        send_event(OP_HOST_READ,     8'h00, 8'h00);
        // A transmit flush leaves the transmitter on; the next ready turns
        // it off because the ring is empty.
        send_event(OP_HOST_WRITE,    8'h00, 8'hA5);
        send_event(OP_HOST_WRITE,    8'h00, 8'h3C);
        send_event(OP_FLUSH_TX,      8'hFF, 8'hFF);
        send_event(OP_LINE_TX_READY, 8'h00, 8'h00);
        send_event(OP_LINE_TX_READY, 8'h00, 8'h00);
        wait_drained();

        run_mix(PHASE_ITEMS);
        wait_drained();

        // Phase two: the roles swap, now the sender is the slow one.
        src_idle_pct = 51;
        sink_idle_pct <= 15;
        run_mix(PHASE_ITEMS);
        wait_drained();

        // Phase three: no idling at all. It opens with a long hold-off on
        // the result side while items keep coming, so the block fills its
        // single slot and holds its input ready low.
        src_idle_pct = 0;
        sink_idle_pct <= 0;
        hold_requests <= hold_requests + 1;
        run_mix(PHASE_ITEMS);
        wait_drained();

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
